// ===== design/set_union_intersection_assert.svh =====
// Assertion macros for the set union / intersection block.
`ifndef SET_UNION_INTERSECTION_ASSERT_SVH
`define SET_UNION_INTERSECTION_ASSERT_SVH

`ifndef SYNTHESIS

`define SUI_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("sui assertion failed");

`define SUI_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("sui assertion failed");

`else

`define SUI_ASSERT_NOW(lbl, clk, rst_n, ante, cons)

`define SUI_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// ===== design/sui_pkg.sv =====
package sui_pkg;

	localparam int DEF_TABLE_ENTRIES = 256;

	typedef enum logic [1:0] {
		CMD_A     = 2'd0,
		CMD_B     = 2'd1,
		CMD_CLEAR = 2'd2
	} cmd_t;

	localparam logic SET_UNION = 1'b0;
	localparam logic SET_INTER = 1'b1;

	localparam logic STAT_OK   = 1'b0;
	localparam logic STAT_FULL = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CMP,
		ST_RED,
		ST_UPD
	} state_t;

	typedef struct packed {
		logic cmp;
		logic shift;
		logic set_a;
		logic set_inter;
		logic clear;
	} cell_ctl_t;

	typedef struct packed {
		logic signed [31:0] value;
		logic               occ;
		logic               from_a;
		logic               in_inter;
	} cell_data_t;

endpackage

// ===== design/sui_in_if.sv =====
interface sui_in_if;
	logic               valid;
	logic               ready;
	logic [1:0]         cmd;
	logic signed [31:0] value;

	modport source (output valid, output cmd, output value, input ready);
	modport sink (input valid, input cmd, input value, output ready);
endinterface

// ===== design/sui_out_if.sv =====
interface sui_out_if;
	logic               valid;
	logic               ready;
	logic               which_set;
	logic signed [31:0] member;
	logic [7:0]         position;
	logic               status;

	modport source (output valid, output which_set, output member, output position,
		output status, input ready);
	modport sink (input valid, input which_set, input member, input position,
		input status, output ready);
endinterface

// ===== design/sui_cell.sv =====
module sui_cell (
	input  logic                clk,
	input  logic                arst_n,
	input  sui_pkg::cell_ctl_t  ctl,
	input  logic signed [31:0]  key,
	input  sui_pkg::cell_data_t prev,
	output sui_pkg::cell_data_t cur,
	output logic                hit,
	output logic                emit
);

	logic signed [31:0] value_q;
	logic               occ_q;
	logic               from_a_q;
	logic               in_inter_q;
	logic               hit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= 1'b0;
			hit_q <= 1'b0;
		end else begin
			if (ctl.clear) begin
				occ_q <= 1'b0;
			end else if (ctl.shift) begin
				occ_q <= prev.occ;
			end
			if (ctl.cmp) begin
				hit_q <= occ_q && (value_q == key);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.shift) begin
			value_q    <= prev.value;
			from_a_q   <= prev.from_a;
			in_inter_q <= prev.in_inter;
		end else begin
			if (ctl.set_a && hit_q) begin
				from_a_q <= 1'b1;
			end
			if (ctl.set_inter && hit_q) begin
				in_inter_q <= 1'b1;
			end
		end
	end

	assign cur.value    = value_q;
	assign cur.occ      = occ_q;
	assign cur.from_a   = from_a_q;
	assign cur.in_inter = in_inter_q;
	assign hit          = hit_q;
	assign emit         = hit_q && from_a_q && !in_inter_q;

endmodule

// ===== design/set_union_intersection.sv =====
// Streaming set union / intersection with duplicate removal.
// in_ch carries items {cmd, value}: cmd A adds a set-A element, B a set-B
// element, CLEAR empties the table; other codes are dropped silently.
// out_ch carries {which_set, member, position, status}: one item for each new
// distinct value (union, position = union index), for each first B match of an
// A-marked value (intersection, position = intersection index), or for a new
// value that finds the table full (status set, position 0).
// The table is a row of TABLE_ENTRIES cells; a new value enters at the head
// and every entry moves one cell down, so each cell compares its own entry.
// An A/B item goes through accept, per-cell compare, hit reduction across the
// row, then update and result load. The result is valid in the cycle after the
// update. CLEAR and unused codes give no item; in_ch is ready again in the
// cycle after.
// If out_ch stalls, the finished result waits in the output register while
// the next item is accepted and searched; that item holds in its update step
// only if it needs the output register too.
// Reset empties the table and both counters; no clearing pass is needed.
`include "set_union_intersection_assert.svh"

module set_union_intersection #(
	parameter int TABLE_ENTRIES = sui_pkg::DEF_TABLE_ENTRIES
) (
	input logic        clk,
	input logic        arst_n,
	sui_in_if.sink     in_ch,
	sui_out_if.source  out_ch
);

	localparam int CW = $clog2(TABLE_ENTRIES + 1);

	sui_pkg::state_t     state_q, state_d;
	sui_pkg::cell_ctl_t  ctl;
	sui_pkg::cell_data_t head;
	sui_pkg::cell_data_t chain [TABLE_ENTRIES];

	logic [TABLE_ENTRIES-1:0] hit_vec;
	logic [TABLE_ENTRIES-1:0] emit_vec;

	logic signed [31:0] key_q;
	logic               is_a_q;
	logic               any_hit_q;
	logic               any_emit_q;
	logic [CW-1:0]      union_count_q;
	logic [CW-1:0]      inter_count_q;

	logic               out_valid_q;
	logic               which_set_q;
	logic signed [31:0] member_q;
	logic [7:0]         position_q;
	logic               status_q;

	logic               accept;
	logic               full;
	logic               need_result;
	logic               out_free;
	logic               load;
	logic               union_inc;
	logic               inter_inc;
	logic               count_clr;
	logic               res_which;
	logic [7:0]         res_pos;
	logic               res_status;
	logic [CW+7:0]      union_pos_ext;
	logic [CW+7:0]      inter_pos_ext;

	assign accept        = in_ch.valid && in_ch.ready;
	assign full          = (union_count_q == CW'(TABLE_ENTRIES));
	assign need_result   = !any_hit_q || (!is_a_q && any_emit_q);
	assign out_free      = !out_valid_q || out_ch.ready;
	assign union_pos_ext = {8'b0, union_count_q};
	assign inter_pos_ext = {8'b0, inter_count_q};

	assign head.value    = key_q;
	assign head.occ      = 1'b1;
	assign head.from_a   = is_a_q;
	assign head.in_inter = 1'b0;

	for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
		if (i == 0) begin : g_head
			sui_cell u_cell (
				.clk    (clk),
				.arst_n (arst_n),
				.ctl    (ctl),
				.key    (key_q),
				.prev   (head),
				.cur    (chain[i]),
				.hit    (hit_vec[i]),
				.emit   (emit_vec[i])
			);
		end else begin : g_body
			sui_cell u_cell (
				.clk    (clk),
				.arst_n (arst_n),
				.ctl    (ctl),
				.key    (key_q),
				.prev   (chain[i-1]),
				.cur    (chain[i]),
				.hit    (hit_vec[i]),
				.emit   (emit_vec[i])
			);
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			sui_pkg::ST_IDLE: begin
				if (accept && (in_ch.cmd == sui_pkg::CMD_A || in_ch.cmd == sui_pkg::CMD_B)) begin
					state_d = sui_pkg::ST_CMP;
				end
			end
			sui_pkg::ST_CMP: state_d = sui_pkg::ST_RED;
			sui_pkg::ST_RED: state_d = sui_pkg::ST_UPD;
			sui_pkg::ST_UPD: begin
				if (!need_result || out_free) begin
					state_d = sui_pkg::ST_IDLE;
				end
			end
			default: state_d = sui_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		in_ch.ready   = 1'b0;
		ctl           = '0;
		load          = 1'b0;
		union_inc     = 1'b0;
		inter_inc     = 1'b0;
		count_clr     = 1'b0;
		res_which     = sui_pkg::SET_UNION;
		res_pos       = union_pos_ext[7:0];
		res_status    = sui_pkg::STAT_OK;
		unique case (state_q)
			sui_pkg::ST_IDLE: begin
				in_ch.ready = 1'b1;
				if (accept && in_ch.cmd == sui_pkg::CMD_CLEAR) begin
					ctl.clear = 1'b1;
					count_clr = 1'b1;
				end
			end
			sui_pkg::ST_CMP: ctl.cmp = 1'b1;
			sui_pkg::ST_RED: ;
			sui_pkg::ST_UPD: begin
				if (!any_hit_q) begin
					if (out_free) begin
						load = 1'b1;
						if (full) begin
							res_pos    = 8'd0;
							res_status = sui_pkg::STAT_FULL;
						end else begin
							ctl.shift = 1'b1;
							union_inc = 1'b1;
						end
					end
				end else if (is_a_q) begin
					ctl.set_a = 1'b1;
				end else if (any_emit_q && out_free) begin
					ctl.set_inter = 1'b1;
					inter_inc     = 1'b1;
					load          = 1'b1;
					res_which     = sui_pkg::SET_INTER;
					res_pos       = inter_pos_ext[7:0];
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= sui_pkg::ST_IDLE;
			union_count_q <= '0;
			inter_count_q <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (count_clr) begin
				union_count_q <= '0;
				inter_count_q <= '0;
			end else begin
				if (union_inc) begin
					union_count_q <= union_count_q + CW'(1);
				end
				if (inter_inc) begin
					inter_count_q <= inter_count_q + CW'(1);
				end
			end
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			key_q  <= in_ch.value;
			is_a_q <= (in_ch.cmd == sui_pkg::CMD_A);
		end
		if (state_q == sui_pkg::ST_RED) begin
			any_hit_q  <= |hit_vec;
			any_emit_q <= |emit_vec;
		end
		if (load) begin
			which_set_q <= res_which;
			member_q    <= key_q;
			position_q  <= res_pos;
			status_q    <= res_status;
		end
	end

	assign out_ch.valid     = out_valid_q;
	assign out_ch.which_set = which_set_q;
	assign out_ch.member    = member_q;
	assign out_ch.position  = position_q;
	assign out_ch.status    = status_q;

	`SUI_ASSERT_NOW(a_count_range, clk, arst_n, 1'b1, union_count_q <= CW'(TABLE_ENTRIES))
	`SUI_ASSERT_NOW(a_single_hit, clk, arst_n, state_q == sui_pkg::ST_RED, $onehot0(hit_vec))
	`SUI_ASSERT_NEXT(a_union_grows, clk, arst_n, load && !res_which && !res_status,
		union_count_q == $past(union_count_q) + CW'(1))

endmodule
